/* rtl/core/kmm_pkg.sv */
// Shared types and codes for the k-mismatch pattern matcher.
package kmm_pkg;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned PIDX_W  = 6;
    localparam int unsigned ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } kmm_action_t;

    typedef enum logic [0:0] {
        REG_MISMATCH_LIMIT = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } kmm_reg_idx_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic             step;     // text beat advances the chain
        logic             clear;    // restart: drop all open windows
        logic [SYM_W-1:0] symbol;
        logic [CNT_W-1:0] limit;
        logic [CNT_W-1:0] cap;      // count saturates here
    } kmm_ctrl_t;

endpackage

/* rtl/core/kmm_cell.sv */
// One chain cell: a pattern byte and the mismatch count of one open window.
module kmm_cell
    import kmm_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned LW  = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  kmm_ctrl_t        ctrl,
    input  logic             load_en,
    input  logic [LW-1:0]    len_m1,
    input  logic [CNT_W-1:0] prev_count,
    input  logic             prev_valid,
    output logic [CNT_W-1:0] count,
    output logic             valid,
    output logic             hit
);

    logic [SYM_W-1:0] pattern_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             valid_reg;
    logic             active;
    logic             last;
    logic             miss;

    assign active = (IDX <= 32'(len_m1));
    assign last   = (IDX == 32'(len_m1));
    assign miss   = (ctrl.symbol != pattern_reg);

    // the window arriving from the left takes this cell's pattern byte
    always_comb
    begin
        count_next = prev_count;
        if (active && miss && (prev_count < ctrl.cap))
        begin
            count_next = prev_count + CNT_W'(1);
        end
    end

    assign hit = last && prev_valid && (count_next <= ctrl.limit);

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            pattern_reg <= ctrl.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            count_reg <= count_next;
            valid_reg <= prev_valid;
        end
    end

    assign count = count_reg;
    assign valid = valid_reg;

endmodule

/* rtl/core/k_mismatch_pattern_match_top.sv */
// k-mismatch string matcher: chain of compare cells, one per pattern byte.
// A text beat's result is in the output register the cycle after acceptance.
// Throughput: one item per cycle while the output is drained; the chain advances
// one window per text beat, all counts updating in parallel in the cells.
// Reset: counts, windows and text position cleared; limit 0, length 1;
// pattern bytes are undefined until loaded.
module k_mismatch_pattern_match_top
    import kmm_pkg::*;
#(
    parameter int unsigned MAX_PATTERN   = 64,
    parameter int unsigned POSITION_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    input  logic [PIDX_W-1:0]        pattern_index,
    input  logic [SYM_W-1:0]         symbol,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [POSITION_BITS-1:0] match_start,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int unsigned LW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CNT_W-1:0]         limit_reg;
    logic [CFG_W-1:0]         length_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     out_valid_reg;
    logic [POSITION_BITS-1:0] match_start_reg;

    logic        accept;
    logic        step;
    logic        restart;
    logic        hit_any;
    logic [LW-1:0] len_m1;
    kmm_ctrl_t   ctrl;

    logic [CNT_W-1:0]       chain_count [MAX_PATTERN+1];
    logic                   chain_valid [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign restart   = accept && (kmm_action_t'(action) == ACT_RESTART);
    assign step      = accept && (kmm_action_t'(action) == ACT_TEXT) && (pos_reg != '1);

    // effective length clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_m1 = '0;
        end
        else if (32'(length_reg) > MAX_PATTERN)
        begin
            len_m1 = LW'(MAX_PATTERN - 1);
        end
        else
        begin
            len_m1 = LW'(32'(length_reg) - 32'd1);
        end
    end

    assign ctrl.step   = step;
    assign ctrl.clear  = restart;
    assign ctrl.symbol = symbol;
    assign ctrl.limit  = limit_reg;
    assign ctrl.cap    = (limit_reg == '1) ? limit_reg : limit_reg + CNT_W'(1);

    // a fresh window enters at the head of the chain
    assign chain_count[0] = '0;
    assign chain_valid[0] = 1'b1;

    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        logic load_en;
        assign load_en = accept && (kmm_action_t'(action) == ACT_LOAD)
                         && (32'(pattern_index) == g);

        kmm_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_en    (load_en),
            .len_m1     (len_m1),
            .prev_count (chain_count[g]),
            .prev_valid (chain_valid[g]),
            .count      (chain_count[g+1]),
            .valid      (chain_valid[g+1]),
            .hit        (hits[g])
        );
    end

    assign hit_any = |hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= '0;
            length_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (kmm_reg_idx_t'(cfg_index))
                REG_MISMATCH_LIMIT: limit_reg  <= cfg_data;
                REG_PATTERN_LENGTH: length_reg <= cfg_data;
                default:            limit_reg  <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                pos_reg <= '0;
            end
            else if (step)
            begin
                pos_reg <= pos_reg + POSITION_BITS'(1);
            end

            if (accept)
            begin
                out_valid_reg <= step && hit_any;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hit_any)
        begin
            match_start_reg <= pos_reg - POSITION_BITS'(len_m1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_start = match_start_reg;

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (pos_reg == '0))
        else $error("text position not cleared by restart");

    a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (pos_reg == $past(pos_reg) + POSITION_BITS'(1)))
        else $error("text position did not advance on a text beat");

    a_result_from_text: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a text beat");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the k-mismatch pattern matcher: queued driver, result monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kmm_pkg::*;

    localparam int DEPTH    = 64;
    localparam int PBITS    = 20;
    localparam int TEXT_MAX = (1 << PBITS) - 1;

    typedef struct packed {
        kmm_action_t       act;
        logic [PIDX_W-1:0] idx;
        logic [SYM_W-1:0]  sym;
    } kmm_item_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action        = ACT_LOAD;
    logic [PIDX_W-1:0] pattern_index = '0;
    logic [SYM_W-1:0]  symbol        = '0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [PBITS-1:0]  match_start;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index     = REG_MISMATCH_LIMIT;
    logic [CFG_W-1:0]  cfg_data      = '0;

    // matcher state as the block should hold it
    logic [SYM_W-1:0] pat_mem [DEPTH];
    logic [CNT_W-1:0] win_cnt [DEPTH];
    logic [PBITS-1:0] txt_pos;
    logic [CFG_W-1:0] lim;
    logic [CFG_W-1:0] plen;
    logic [PBITS-1:0] starts_due [$];
    logic [PBITS-1:0] want_start;

    // stimulus side
    kmm_item_t        pending [$];
    kmm_item_t        beat_next;
    logic [SYM_W-1:0] gen_pat [DEPTH];
    bit               loaded [DEPTH];
    int               items_sent;
    int               gap_pct;
    int               stall_pct;
    int               gap_left;
    int               stall_left;
    bit               calm;
    bit               hold_go;
    logic             out_hold = 1'b0;
    int               errors;

    always #2 clk = ~clk;

    k_mismatch_pattern_match_top #(
        .MAX_PATTERN   (DEPTH),
        .POSITION_BITS (PBITS)
    ) uut (.*);

    function automatic int eff_len();
        if (plen == 0)
            return 1;
        if (plen > DEPTH)
            return DEPTH;
        return int'(plen);
    endfunction

    task automatic advance_matcher(kmm_action_t act, logic [PIDX_W-1:0] idx,
                                   logic [SYM_W-1:0] sym);
        int len;
        int cap;
        int pos;
        int first;
        int d;
        case (act)
            ACT_LOAD:
                pat_mem[idx] = sym;
            ACT_RESTART:
            begin
                foreach (win_cnt[i])
                    win_cnt[i] = '0;
                txt_pos = '0;
            end
            ACT_TEXT:
            begin
                pos = int'(txt_pos);
                if (pos < TEXT_MAX)
                begin
                    len = eff_len();
                    cap = int'(lim) + 1;
                    if (cap > 127)
                        cap = 127;
                    // a new window opens at this byte
                    win_cnt[pos % DEPTH] = '0;
                    for (d = 0; d < len && d <= pos; d++)
                        if (sym != pat_mem[d] && win_cnt[(pos - d) % DEPTH] < cap)
                            win_cnt[(pos - d) % DEPTH] = win_cnt[(pos - d) % DEPTH] + 1'b1;
                    txt_pos = txt_pos + 1'b1;
                    if (pos + 1 >= len)
                    begin
                        first = pos + 1 - len;
                        if (win_cnt[first % DEPTH] <= lim)
                            starts_due.push_back(PBITS'(first));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_error(string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endtask

    task automatic push_item(kmm_action_t act, logic [PIDX_W-1:0] idx, logic [SYM_W-1:0] sym);
        kmm_item_t beat;
        beat.act = act;
        beat.idx = idx;
        beat.sym = sym;
        while (pending.size() >= 256)
            @(negedge clk);
        pending.push_back(beat);
        if (act == ACT_LOAD)
        begin
            gen_pat[idx] = sym;
            loaded[idx]  = 1'b1;
        end
        if (act != ACT_NONE)
            items_sent++;
    endtask

    // every pattern byte a window can compare against must be written first
    task automatic fill_pattern(int len);
        int i;
        for (i = 0; i < len; i++)
            if (!loaded[i])
                push_item(ACT_LOAD, PIDX_W'(i), SYM_W'($urandom));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_valid || starts_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(kmm_reg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MISMATCH_LIMIT)
            lim = val;
        else
            plen = val;
        @(negedge clk);
    endtask

    // mostly copies of the pattern with a few flipped bytes, plus noise
    task automatic run_text_phase(int count);
        int len;
        int goal;
        int r;
        int mut;
        int k;
        bit narrow;
        logic [SYM_W-1:0] s;
        len    = eff_len();
        narrow = $urandom_range(1);
        goal   = items_sent + count;
        fill_pattern(len);
        while (items_sent < goal)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                mut = (int'(lim) + 2 < len) ? int'(lim) + 2 : len;
                mut = $urandom_range(mut);
                for (k = 0; k < len; k++)
                begin
                    s = gen_pat[k];
                    if ($urandom_range(len - 1) < mut)
                        s ^= SYM_W'($urandom_range(255, 1));
                    push_item(ACT_TEXT, PIDX_W'($urandom), s);
                end
            end
            else if (r < 80)
            begin
                for (k = $urandom_range(8, 1); k > 0; k--)
                begin
                    s = narrow ? gen_pat[$urandom_range(len - 1)] : SYM_W'($urandom);
                    push_item(ACT_TEXT, PIDX_W'($urandom), s);
                end
            end
            else if (r < 86)
                push_item(ACT_LOAD, PIDX_W'($urandom), SYM_W'($urandom));
            else if (r < 90)
                push_item(ACT_RESTART, PIDX_W'($urandom), SYM_W'($urandom));
            else if (r < 95)
                push_item(ACT_NONE, PIDX_W'($urandom), SYM_W'($urandom));
            else
                push_item(ACT_TEXT, PIDX_W'($urandom), SYM_W'($urandom));
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_matcher(kmm_action_t'(action), pattern_index, symbol);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    beat_next = pending.pop_front();
                    in_valid      <= 1'b1;
                    action        <= beat_next.act;
                    pattern_index <= beat_next.idx;
                    symbol        <= beat_next.sym;
                    if (!calm && $urandom_range(99) < gap_pct)
                        gap_left = $urandom_range(11, 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (starts_due.size() == 0)
                    note_error($sformatf("match_start %0d with no match pending", match_start));
                else
                begin
                    want_start = starts_due.pop_front();
                    if (match_start !== want_start)
                        note_error($sformatf("match_start: expected %0d, got %0d",
                                             want_start, match_start));
                end
            end
            if (out_hold)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(99) < stall_pct)
                    stall_left = $urandom_range(11, 1);
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (200) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        logic [CFG_W-1:0] lim_pick;
        logic [CFG_W-1:0] len_pick;

        foreach (win_cnt[i])
            win_cnt[i] = '0;
        txt_pos   = '0;
        lim       = '0;
        plen      = 7'd1;
        gap_pct   = 20;
        stall_pct = 20;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: limit 0, length 1
        push_item(ACT_LOAD, 6'd0, 8'h00);
        push_item(ACT_LOAD, 6'd63, 8'hFF);
        push_item(ACT_TEXT, 6'd63, 8'h00);
        push_item(ACT_TEXT, 6'd0, 8'hFF);
        push_item(ACT_NONE, 6'd63, 8'hFF);
        push_item(ACT_TEXT, 6'd21, 8'h00);
        push_item(ACT_RESTART, 6'd63, 8'hFF);
        push_item(ACT_TEXT, 6'd42, 8'h00);
        push_item(ACT_LOAD, 6'd0, 8'hFF);
        push_item(ACT_TEXT, 6'd0, 8'hFF);
        push_item(ACT_TEXT, 6'd0, 8'h00);
        wait_idle();
        // widest limit, zero length behaves as one
        set_reg(REG_MISMATCH_LIMIT, 7'd127);
        set_reg(REG_PATTERN_LENGTH, 7'd0);
        push_item(ACT_TEXT, 6'd5, 8'h5A);
        push_item(ACT_TEXT, 6'd10, 8'hA5);
        wait_idle();

        // text position carries across phases, so settings change mid-stream
        for (ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:
                begin
                    lim_pick = 7'd64;
                    len_pick = 7'd127;
                end
                1:
                begin
                    lim_pick = 7'd0;
                    len_pick = 7'd64;
                end
                default:
                begin
                    case ($urandom_range(4))
                        0:       lim_pick = 7'd0;
                        1:       lim_pick = CFG_W'($urandom_range(4, 1));
                        2:       lim_pick = CFG_W'($urandom_range(20));
                        3:       lim_pick = 7'd64;
                        default: lim_pick = 7'd127;
                    endcase
                    case ($urandom_range(5))
                        0:       len_pick = 7'd0;
                        1:       len_pick = CFG_W'($urandom_range(6, 1));
                        2:       len_pick = CFG_W'($urandom_range(16, 2));
                        3:       len_pick = CFG_W'($urandom_range(64, 1));
                        4:       len_pick = 7'd64;
                        default: len_pick = CFG_W'($urandom_range(127, 65));
                    endcase
                end
            endcase
            gap_pct   = (ph % 3 == 2) ? 0 : $urandom_range(40, 5);
            stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(40, 5);
            set_reg(REG_MISMATCH_LIMIT, lim_pick);
            set_reg(REG_PATTERN_LENGTH, len_pick);
            run_text_phase(115);
            wait_idle();
        end

        // every window matches while the receiver holds off
        gap_pct   = 0;
        stall_pct = 0;
        set_reg(REG_MISMATCH_LIMIT, 7'd127);
        set_reg(REG_PATTERN_LENGTH, 7'd3);
        fill_pattern(3);
        hold_go = 1'b1;
        for (n = 0; n < 150; n++)
            push_item(ACT_TEXT, PIDX_W'($urandom), SYM_W'($urandom));
        wait_idle();

        // restarts around a short exact-match stream, no idling to the end
        calm = 1'b1;
        set_reg(REG_MISMATCH_LIMIT, 7'd0);
        set_reg(REG_PATTERN_LENGTH, 7'd1);
        push_item(ACT_RESTART, '0, '0);
        for (n = 0; n < 40; n++)
            push_item(ACT_TEXT, PIDX_W'($urandom), n[0] ? gen_pat[0] : SYM_W'($urandom));
        push_item(ACT_RESTART, '1, '1);
        push_item(ACT_TEXT, 6'd0, gen_pat[0]);
        wait_idle();
        repeat (8) @(negedge clk);

        if (errors == 0 && starts_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
